[hw/rtl/td_pkg.sv]
package td_pkg;

    localparam int QW = 32;
    localparam int TicksPerSecondDef = 1000;
    localparam int FracBitsDef = 16;
    localparam int RateDivisor = 1000;

    localparam logic [31:0] SpeedReset = 32'd6553600;
    localparam logic signed [31:0] QMax = 32'sh7fffffff;
    localparam logic signed [31:0] QMin = 32'sh80000000;

    // step counts of the bit-serial unit, last step index
    localparam int SerCntW = 6;
    localparam logic [SerCntW-1:0] MulLast = 6'd31;
    localparam logic [SerCntW-1:0] DivLast = 6'd63;
    localparam logic [SerCntW-1:0] SqrtLast = 6'd31;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_ser_op;

    typedef struct packed {
        logic    start;
        t_ser_op op;
    } t_ser_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_H_GO,
        S_H_WT,
        S_HX_GO,
        S_HX_WT,
        S_RH_GO,
        S_RH_WT,
        S_D_GO,
        S_D_WT,
        S_INNER,
        S_P_GO,
        S_P_WT,
        S_SQ_GO,
        S_SQ_WT,
        S_HALF,
        S_A1,
        S_S,
        S_A,
        S_Q_GO,
        S_Q_WT,
        S_T1,
        S_T2,
        S_T3,
        S_ACC_GO,
        S_ACC_WT,
        S_V_GO,
        S_V_WT,
        S_R_GO,
        S_R_WT,
        S_UPD
    } t_state;

endpackage

[hw/rtl/td_serial.sv]
module td_serial import td_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ser_req    i_req,
    input  logic [63:0] i_opa,
    input  logic [31:0] i_opb,
    output logic        o_done,
    output logic [63:0] o_result
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    t_ser_op            r_op, n_op;
    logic [SerCntW-1:0] r_cnt, n_cnt;
    logic [63:0]        r_acc, n_acc;
    logic [33:0]        r_rem, n_rem;
    logic [31:0]        r_b, n_b;
    logic [31:0]        r_root, n_root;

    logic [SerCntW-1:0] w_last;
    logic [32:0]        w_msum;
    logic [32:0]        w_dtmp;
    logic [33:0]        w_stmp;
    logic [33:0]        w_trial;

    always_comb begin
        case (r_op)
            OP_MUL:  w_last = MulLast;
            OP_DIV:  w_last = DivLast;
            OP_SQRT: w_last = SqrtLast;
            default: w_last = MulLast;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_b    = r_b;
        n_root = r_root;
        w_msum  = {1'b0, r_acc[63:32]} + (r_acc[0] ? {1'b0, r_b} : 33'd0);
        w_dtmp  = {r_rem[31:0], r_acc[63]};
        w_stmp  = {r_rem[31:0], r_acc[63:62]};
        w_trial = {r_root, 2'b01};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = '0;
            n_acc  = (i_req.op == OP_MUL) ? {32'd0, i_opa[31:0]} : i_opa;
            n_rem  = '0;
            n_b    = i_opb;
            n_root = '0;
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    // shift-add, product builds from the top
                    n_acc = {w_msum, r_acc[31:1]};
                end
                OP_DIV: begin
                    // restoring division, quotient bits shift in as dividend bits leave
                    if (w_dtmp >= {1'b0, r_b}) begin
                        n_rem = {2'b00, 32'(w_dtmp - {1'b0, r_b})};
                        n_acc = {r_acc[62:0], 1'b1};
                    end else begin
                        n_rem = {2'b00, w_dtmp[31:0]};
                        n_acc = {r_acc[62:0], 1'b0};
                    end
                end
                OP_SQRT: begin
                    // one root bit per step from two radicand bits
                    if (w_stmp >= w_trial) begin
                        n_rem  = w_stmp - w_trial;
                        n_root = {r_root[30:0], 1'b1};
                    end else begin
                        n_rem  = w_stmp;
                        n_root = {r_root[30:0], 1'b0};
                    end
                    n_acc = {r_acc[61:0], 2'b00};
                end
                default: begin
                end
            endcase
            if (r_cnt == w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_b    <= n_b;
        r_root <= n_root;
    end

    assign o_done   = r_done;
    assign o_result = (r_op == OP_SQRT) ? {32'd0, r_root} : r_acc;

endmodule

[hw/rtl/tracking_differentiator_core.sv]
// tracking differentiator, steepest-tracking law on signed fixed point
//
// input channel: i_in_valid / o_in_stall with i_target and i_elapsed_ticks.
// a request is taken when valid is high and stall is low; o_in_stall stays
// high while a request is being worked on.
// output channel: o_out_valid / i_out_stall with o_tracked_value and
// o_tracked_rate, one result per request.
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_data, the speed
// factor; ready is always high, write only while the block is idle.
// one request at a time; the work is done by one shared bit-serial unit:
// four divisions, five multiplications and one square root, plus the
// sequencer's own states.
// a finished result sits in the output register; the next request is taken
// while it waits, but the state update at the end of that request holds
// until the receiver has taken the previous result.
// reset: speed factor back to 100.0, tracked value and rate cleared.
module tracking_differentiator_core import td_pkg::*; #(
    parameter int TICKS_PER_SECOND = TicksPerSecondDef,
    parameter int FRAC_BITS = FracBitsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_target,
    input  logic [15:0]        i_elapsed_ticks,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_tracked_value,
    output logic signed [31:0] o_tracked_rate,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);

    localparam logic signed [63:0] One = 64'sd1 <<< FRAC_BITS;

    function automatic logic signed [31:0] f_sat(input logic signed [35:0] v);
        logic signed [31:0] res;
        if (v > 36'(QMax)) begin
            res = QMax;
        end else if (v < 36'(QMin)) begin
            res = QMin;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [35:0] f_ext(input logic signed [31:0] v);
        return 36'(v);
    endfunction

    function automatic logic [31:0] f_mag(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // scaled product magnitude back to a saturated signed value
    function automatic logic signed [31:0] f_qfix(input logic [63:0] p, input logic neg);
        logic signed [31:0] res;
        if (neg) begin
            res = (p >= 64'h8000_0000) ? QMin : 32'(-p);
        end else begin
            res = (p >= 64'h7fff_ffff) ? QMax : p[31:0];
        end
        return res;
    endfunction

    // twice the switching term: inside the band, on its edge, outside
    function automatic logic [1:0] f_sw(input logic [31:0] m, input logic [31:0] d);
        logic [1:0] res;
        if (m < d) begin
            res = 2'd2;
        end else if (m == d) begin
            res = 2'd1;
        end else begin
            res = 2'd0;
        end
        return res;
    endfunction

    t_state             r_state, n_state;
    logic signed [31:0] r_x1, n_x1;
    logic [15:0]        r_ticks, n_ticks;
    logic [31:0]        r_h, n_h;
    logic signed [31:0] r_hx2, n_hx2;
    logic [31:0]        r_rh, n_rh;
    logic [31:0]        r_d, n_d;
    logic signed [31:0] r_y, n_y;
    logic [31:0]        r_inner, n_inner;
    logic [1:0]         r_sy2, n_sy2;
    logic [31:0]        r_a0, n_a0;
    logic signed [33:0] r_half, n_half;
    logic signed [31:0] r_a1, n_a1;
    logic signed [31:0] r_s, n_s;
    logic signed [31:0] r_a, n_a;
    logic [1:0]         r_sa2, n_sa2;
    logic signed [63:0] r_q, n_q;
    logic signed [63:0] r_t, n_t;
    logic signed [31:0] r_fst, n_fst;
    logic signed [31:0] r_vdiv, n_vdiv;
    logic signed [31:0] r_rdiv, n_rdiv;
    logic signed [31:0] r_value, n_value;
    logic signed [31:0] r_rate, n_rate;
    logic [31:0]        r_speed, n_speed;
    logic               r_out_valid, n_out_valid;

    t_ser_req           ser_req;
    logic [63:0]        ser_opa;
    logic [31:0]        ser_opb;
    logic               ser_done;
    logic [63:0]        ser_result;

    logic signed [63:0] w_sa_one;
    logic [35:0]        c_inner;
    logic signed [33:0] c_diff;
    logic signed [33:0] c_diff_adj;
    logic signed [35:0] c_part;
    logic signed [63:0] c_tadj;
    logic [63:0]        c_tabs;
    logic signed [31:0] c_d;
    logic signed [31:0] c_acc;

    assign w_sa_one = r_a[31] ? -One : ((r_a != '0) ? One : 64'sd0);

    always_comb begin
        n_state     = r_state;
        n_x1        = r_x1;
        n_ticks     = r_ticks;
        n_h         = r_h;
        n_hx2       = r_hx2;
        n_rh        = r_rh;
        n_d         = r_d;
        n_y         = r_y;
        n_inner     = r_inner;
        n_sy2       = r_sy2;
        n_a0        = r_a0;
        n_half      = r_half;
        n_a1        = r_a1;
        n_s         = r_s;
        n_a         = r_a;
        n_sa2       = r_sa2;
        n_q         = r_q;
        n_t         = r_t;
        n_fst       = r_fst;
        n_vdiv      = r_vdiv;
        n_rdiv      = r_rdiv;
        n_value     = r_value;
        n_rate      = r_rate;
        n_speed     = i_cfg_valid ? i_cfg_data : r_speed;
        n_out_valid = r_out_valid && i_out_stall;
        ser_req.start = 1'b0;
        ser_req.op    = OP_MUL;
        ser_opa       = '0;
        ser_opb       = '0;
        c_inner    = {4'd0, r_d} + {1'b0, f_mag(r_y), 3'b000};
        c_diff     = $signed({2'b00, r_a0}) - $signed({2'b00, r_d});
        c_diff_adj = c_diff + $signed({33'd0, c_diff[33]});
        c_part     = '0;
        c_tadj     = r_t + $signed({63'd0, r_t[63]});
        c_tabs     = r_t[63] ? 64'(-r_t) : 64'(r_t);
        c_d        = f_qfix(ser_result >> FRAC_BITS, 1'b0);
        c_acc      = f_qfix(ser_result >> FRAC_BITS, r_t[63]);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x1    = f_sat(f_ext(r_value) - f_ext(i_target));
                    n_ticks = i_elapsed_ticks;
                    n_state = S_H_GO;
                end
            end
            S_H_GO: begin
                ser_req.start = 1'b1;
                ser_req.op    = OP_DIV;
                ser_opa       = 64'(r_ticks) << FRAC_BITS;
                ser_opb       = 32'(TICKS_PER_SECOND);
                n_state       = S_H_WT;
            end
            S_H_WT: begin
                if (ser_done) begin
                    n_h     = (|ser_result[63:32]) ? '1 : ser_result[31:0];
                    n_state = S_HX_GO;
                end
            end
            S_HX_GO: begin
                ser_req.start = 1'b1;
                ser_req.op    = OP_MUL;
                ser_opa       = 64'(r_h);
                ser_opb       = f_mag(r_rate);
                n_state       = S_HX_WT;
            end
            S_HX_WT: begin
                if (ser_done) begin
                    n_hx2   = f_qfix(ser_result >> FRAC_BITS, r_rate[31]);
                    n_state = S_RH_GO;
                end
            end
            S_RH_GO: begin
                ser_req.start = 1'b1;
                ser_req.op    = OP_MUL;
                ser_opa       = 64'(r_speed);
                ser_opb       = r_h;
                n_y           = f_sat(f_ext(r_x1) + f_ext(r_hx2));
                n_state       = S_RH_WT;
            end
            S_RH_WT: begin
                if (ser_done) begin
                    n_rh    = c_d;
                    n_state = S_D_GO;
                end
            end
            S_D_GO: begin
                ser_req.start = 1'b1;
                ser_req.op    = OP_MUL;
                ser_opa       = 64'(r_rh);
                ser_opb       = r_h;
                n_state       = S_D_WT;
            end
            S_D_WT: begin
                if (ser_done) begin
                    // a step too short for any gain falls back to one lsb
                    n_d     = (c_d == '0) ? 32'd1 : c_d;
                    n_state = S_INNER;
                end
            end
            S_INNER: begin
                n_inner = (|c_inner[35:32]) ? '1 : c_inner[31:0];
                n_sy2   = f_sw(f_mag(r_y), r_d);
                n_state = S_P_GO;
            end
            S_P_GO: begin
                ser_req.start = 1'b1;
                ser_req.op    = OP_MUL;
                ser_opa       = 64'(r_d);
                ser_opb       = r_inner;
                n_state       = S_P_WT;
            end
            S_P_WT: begin
                if (ser_done) begin
                    n_state = S_SQ_GO;
                end
            end
            S_SQ_GO: begin
                ser_req.start = 1'b1;
                ser_req.op    = OP_SQRT;
                ser_opa       = ser_result;
                n_state       = S_SQ_WT;
            end
            S_SQ_WT: begin
                if (ser_done) begin
                    n_a0    = ser_result[31:0];
                    n_state = S_HALF;
                end
            end
            S_HALF: begin
                n_half  = c_diff_adj >>> 1;
                n_state = S_A1;
            end
            S_A1: begin
                if (r_y[31]) begin
                    c_part = -36'(r_half);
                end else if (r_y != '0) begin
                    c_part = 36'(r_half);
                end
                n_a1    = f_sat(c_part + f_ext(r_hx2));
                n_state = S_S;
            end
            S_S: begin
                n_s     = f_sat(f_ext(r_hx2) + f_ext(r_y) - f_ext(r_a1));
                n_state = S_A;
            end
            S_A: begin
                case (r_sy2)
                    2'd2:    c_part = f_ext(r_s);
                    2'd1:    c_part = (f_ext(r_s) + $signed({35'd0, r_s[31]})) >>> 1;
                    default: c_part = '0;
                endcase
                n_a     = f_sat(c_part + f_ext(r_a1));
                n_state = S_Q_GO;
            end
            S_Q_GO: begin
                n_sa2         = f_sw(f_mag(r_a), r_d);
                ser_req.start = 1'b1;
                ser_req.op    = OP_DIV;
                ser_opa       = 64'(f_mag(r_a)) << FRAC_BITS;
                ser_opb       = r_d;
                n_state       = S_Q_WT;
            end
            S_Q_WT: begin
                if (ser_done) begin
                    n_q     = r_a[31] ? -$signed(ser_result) : $signed(ser_result);
                    n_state = S_T1;
                end
            end
            S_T1: begin
                n_t     = r_q - w_sa_one;
                n_state = S_T2;
            end
            S_T2: begin
                n_t     = c_tadj >>> 1;
                n_state = S_T3;
            end
            S_T3: begin
                case (r_sa2)
                    2'd0:    n_t = w_sa_one;
                    2'd2:    n_t = r_q;
                    default: n_t = r_t + w_sa_one;
                endcase
                n_state = S_ACC_GO;
            end
            S_ACC_GO: begin
                ser_req.start = 1'b1;
                ser_req.op    = OP_MUL;
                ser_opa       = 64'(r_speed);
                ser_opb       = (|c_tabs[63:32]) ? '1 : c_tabs[31:0];
                n_state       = S_ACC_WT;
            end
            S_ACC_WT: begin
                if (ser_done) begin
                    n_fst   = (c_acc == QMin) ? QMax : -c_acc;
                    n_state = S_V_GO;
                end
            end
            S_V_GO: begin
                ser_req.start = 1'b1;
                ser_req.op    = OP_DIV;
                ser_opa       = 64'(f_mag(r_rate));
                ser_opb       = 32'(RateDivisor);
                n_state       = S_V_WT;
            end
            S_V_WT: begin
                if (ser_done) begin
                    n_vdiv  = r_rate[31] ? -$signed(ser_result[31:0])
                                         : $signed(ser_result[31:0]);
                    n_state = S_R_GO;
                end
            end
            S_R_GO: begin
                ser_req.start = 1'b1;
                ser_req.op    = OP_DIV;
                ser_opa       = 64'(f_mag(r_fst));
                ser_opb       = 32'(RateDivisor);
                n_state       = S_R_WT;
            end
            S_R_WT: begin
                if (ser_done) begin
                    n_rdiv  = r_fst[31] ? -$signed(ser_result[31:0])
                                        : $signed(ser_result[31:0]);
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // state doubles as the output register, so wait for a free slot
                if (!r_out_valid || !i_out_stall) begin
                    n_value     = f_sat(f_ext(r_value) + f_ext(r_vdiv));
                    n_rate      = f_sat(f_ext(r_rate) + f_ext(r_rdiv));
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_speed     <= SpeedReset;
            r_value     <= '0;
            r_rate      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_speed     <= n_speed;
            r_value     <= n_value;
            r_rate      <= n_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1    <= n_x1;
        r_ticks <= n_ticks;
        r_h     <= n_h;
        r_hx2   <= n_hx2;
        r_rh    <= n_rh;
        r_d     <= n_d;
        r_y     <= n_y;
        r_inner <= n_inner;
        r_sy2   <= n_sy2;
        r_a0    <= n_a0;
        r_half  <= n_half;
        r_a1    <= n_a1;
        r_s     <= n_s;
        r_a     <= n_a;
        r_sa2   <= n_sa2;
        r_q     <= n_q;
        r_t     <= n_t;
        r_fst   <= n_fst;
        r_vdiv  <= n_vdiv;
        r_rdiv  <= n_rdiv;
    end

    td_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (ser_req),
        .i_opa    (ser_opa),
        .i_opb    (ser_opb),
        .o_done   (ser_done),
        .o_result (ser_result)
    );

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_tracked_value = r_value;
    assign o_tracked_rate  = r_rate;
    assign o_cfg_ready     = 1'b1;

endmodule

[hw/rtl/td_checker.sv]
module td_checker import td_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic signed [31:0] i_target,
    input logic [15:0]        i_elapsed_ticks,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_tracked_value,
    input logic signed [31:0] o_tracked_rate,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [31:0]        i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_tracked_value) && $stable(o_tracked_rate))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a request in progress");

endmodule

bind tracking_differentiator_core td_checker u_td_checker (.*);

[dv/testbench.sv]
module testbench;
    import td_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FracBits = FracBitsDef;
    localparam int TicksPerSec = TicksPerSecondDef;
    localparam int SettleCycles = 600;
    localparam int StallLimit = 20000;
    localparam int LongHold = 3000;
    localparam longint OneQ = longint'(1) << FracBits;
    localparam longint QMaxL = 64'sd2147483647;
    localparam longint QMinL = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] target;
        logic [15:0]        ticks;
    } td_req_t;

    typedef struct {
        logic signed [31:0] value;
        logic signed [31:0] rate;
    } td_res_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [31:0] i_target;
    logic [15:0]        i_elapsed_ticks;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_tracked_value;
    logic signed [31:0] o_tracked_rate;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [31:0]        i_cfg_data;

    tracking_differentiator_core dut (.*);

    td_req_t pending_req_q[$];
    td_res_t expected_track_q[$];

    // predictor state
    logic [31:0]        mdl_speed = SpeedReset;
    logic signed [31:0] mdl_value = '0;
    logic signed [31:0] mdl_rate = '0;

    int err_count = 0;
    int idle_in_pct = 0;
    int idle_out_pct = 0;
    bit req_taken = 0;
    bit hold_start = 0;
    int hold_cnt = 0;
    int quiet_cycles = 0;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint sat32(longint v);
        if (v > QMaxL) return QMaxL;
        if (v < QMinL) return QMinL;
        return v;
    endfunction

    function automatic longint sgn(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint unsigned mag32(longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        return (m > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : m;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint unsigned p;
        bit neg;
        p = (mag32(a) * mag32(b)) >> FracBits;
        neg = (a < 0) != (b < 0);
        if (p > (64'd1 << 32)) p = 64'd1 << 32;
        return sat32(neg ? -longint'(p) : longint'(p));
    endfunction

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint fhan_accel(longint x1, longint x2, longint r, longint h);
        longint hx2, y, d, inner, a0, a1, a, sy2, sa2, sa, q, t;
        hx2 = qmul(h, x2);
        y = sat32(x1 + hx2);
        d = qmul(qmul(r, h), h);
        // degenerate step, fall back to one lsb
        if (d <= 0) d = 1;
        inner = d + 8 * ((y < 0) ? -y : y);
        if (inner > 64'sd4294967295) inner = 64'sd4294967295;
        a0 = longint'(isqrt(longint'(d) * longint'(inner)));
        a1 = sat32(((a0 - d) / 2) * sgn(y) + hx2);
        sy2 = sgn(y + d) - sgn(y - d);
        a = sat32((sat32(hx2 + y - a1) * sy2) / 2 + a1);
        sa2 = sgn(a + d) - sgn(a - d);
        sa = sgn(a);
        q = (a * OneQ) / d;
        t = ((q - sa * OneQ) * sa2) / 2 + sa * OneQ;
        return sat32(-qmul(r, t));
    endfunction

    function automatic td_res_t predict_track(td_req_t req);
        longint h, x1, old_rate, acc;
        td_res_t res;
        h = (longint'(req.ticks) << FracBits) / TicksPerSec;
        x1 = sat32(longint'(mdl_value) - longint'(req.target));
        old_rate = mdl_rate;
        acc = fhan_accel(x1, old_rate, longint'(mdl_speed), h);
        mdl_value = sat32(longint'(mdl_value) + old_rate / RateDivisor);
        mdl_rate = sat32(old_rate + acc / RateDivisor);
        res.value = mdl_value;
        res.rate = mdl_rate;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic signed [31:0] got,
                                   logic signed [31:0] exp_v);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
        err_count++;
    endtask

    // driver
    always @(negedge i_clk) begin
        bit nxt_valid;
        td_req_t req;
        nxt_valid = i_in_valid;
        req.target = i_target;
        req.ticks = i_elapsed_ticks;
        if (req_taken) begin
            nxt_valid = 1'b0;
            req_taken = 0;
        end
        if (!nxt_valid && i_rst_n && pending_req_q.size() > 0 &&
            $urandom_range(99) >= idle_in_pct) begin
            req = pending_req_q.pop_front();
            nxt_valid = 1'b1;
        end
        i_in_valid <= nxt_valid;
        i_target <= req.target;
        i_elapsed_ticks <= req.ticks;
    end

    // receiver stall, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_start) begin
            hold_start = 0;
            hold_cnt = LongHold;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
        end
        i_out_stall <= (hold_cnt > 0) || ($urandom_range(99) < idle_out_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        td_res_t exp_r;
        bit any;
        any = 0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                mdl_speed = i_cfg_data;
                any = 1;
            end
            if (i_in_valid && !o_in_stall) begin
                td_req_t req;
                req.target = i_target;
                req.ticks = i_elapsed_ticks;
                expected_track_q.push_back(predict_track(req));
                req_taken = 1;
                any = 1;
            end
            if (o_out_valid && !i_out_stall) begin
                any = 1;
                if (expected_track_q.size() == 0) begin
                    $display("unexpected result value %0d rate %0d", o_tracked_value,
                             o_tracked_rate);
                    err_count++;
                end else begin
                    exp_r = expected_track_q.pop_front();
                    if (o_tracked_value !== exp_r.value)
                        report_mismatch("tracked_value", o_tracked_value, exp_r.value);
                    if (o_tracked_rate !== exp_r.rate)
                        report_mismatch("tracked_rate", o_tracked_rate, exp_r.rate);
                end
            end
        end
        quiet_cycles = any ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_req(logic signed [31:0] tgt, logic [15:0] tk);
        td_req_t req;
        req.target = tgt;
        req.ticks = tk;
        pending_req_q.push_back(req);
    endtask

    task automatic wait_drained();
        while (pending_req_q.size() > 0 || i_in_valid || expected_track_q.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_speed(logic [31:0] val);
        wait_drained();
        repeat (SettleCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly held targets so the tracker settles, plus noise
    task automatic gen_random(int n);
        int cnt, kind, len;
        logic signed [31:0] tgt;
        cnt = 0;
        while (cnt < n) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                len = $urandom_range(20, 5);
                tgt = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
                repeat (len) push_req(tgt, 16'($urandom_range(20, 1)));
                cnt += len;
            end else if (kind < 8) begin
                push_req($urandom, 16'($urandom));
                cnt++;
            end else begin
                push_req($signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000,
                         ($urandom_range(1) != 0) ? 16'd0 : 16'($urandom_range(65535, 30000)));
                cnt++;
            end
        end
    endtask

    initial begin
        logic [31:0] speeds[6];
        speeds = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'h0001_0000, SpeedReset};
        speeds[3] = $urandom;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_target = '0;
        i_elapsed_ticks = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_in_pct = 35;
        idle_out_pct = 60;
        // directed: field extremes, zero and full-scale steps
        push_req(32'sh0001_0000, 16'd1);
        push_req(32'sh0001_0000, 16'd0);
        push_req(QMax, 16'd1000);
        push_req(QMax, 16'd65535);
        push_req(QMin, 16'd65535);
        push_req(QMin, 16'd1);
        push_req(32'sd0, 16'd0);
        push_req(-32'sd1, 16'd1);
        push_req(32'sd1, 16'd65535);
        push_req(32'sh0005_0000, 16'd10);
        push_req(32'sh0005_0000, 16'd10);
        push_req(32'sh0005_0000, 16'd10);
        push_req(-32'sh0005_0000, 16'd5);
        push_req(-32'sh0005_0000, 16'd5);
        push_req(32'sh5555_5555, 16'hAAAA);
        push_req(32'shAAAA_AAAA, 16'h5555);
        push_req(QMax, 16'd0);
        push_req(QMin, 16'd0);
        gen_random(150);

        for (int ph = 0; ph < 6; ph++) begin
            write_speed(speeds[ph]);
            case ((ph + 1) % 3)
                0: begin idle_in_pct = 35; idle_out_pct = 60; end
                1: begin idle_in_pct = 60; idle_out_pct = 35; end
                default: begin idle_in_pct = 0; idle_out_pct = 0; end
            endcase
            gen_random(75);
            if ((ph + 1) % 3 == 2) hold_start = 1;
            // sender pause until everything is back
            wait_drained();
            gen_random(75);
        end

        wait_drained();
        repeat (SettleCycles) @(posedge i_clk);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
